// ===== rtl/core/lge_pkg.sv =====
// shared types, codes and constants of the life generation engine
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

  // action codes of an input item
  typedef logic [1:0] act_t;
  localparam act_t ACT_WRITE = 2'd0;
  localparam act_t ACT_STEP  = 2'd1;
  localparam act_t ACT_READ  = 2'd2;

  // configuration registers
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  // neighbour counts and the life rule
  localparam int CNT_W = 4;
  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t SURVIVE_LOW = 4'd2;
  localparam cnt_t BIRTH_COUNT = 4'd3;

  // probe order: eight neighbours first, the cell itself last
  localparam int PROBE_W = 4;
  typedef logic [PROBE_W-1:0] probe_t;
  localparam probe_t PROBE_CENTER = 4'd8;

  typedef logic [1:0] ofs_t;
  localparam ofs_t OFS_DEC  = 2'd0;
  localparam ofs_t OFS_KEEP = 2'd1;
  localparam ofs_t OFS_INC  = 2'd2;

  function automatic ofs_t probe_row_ofs(input probe_t p);
    ofs_t o;
    unique case (p)
      4'd0, 4'd1, 4'd2: o = OFS_DEC;
      4'd5, 4'd6, 4'd7: o = OFS_INC;
      default:          o = OFS_KEEP;
    endcase
    return o;
  endfunction

  function automatic ofs_t probe_col_ofs(input probe_t p);
    ofs_t o;
    unique case (p)
      4'd0, 4'd3, 4'd5: o = OFS_DEC;
      4'd2, 4'd4, 4'd7: o = OFS_INC;
      default:          o = OFS_KEEP;
    endcase
    return o;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic clear;        // zero one entry of both stores
    logic accept;       // input item taken this cycle
    logic cell_start;   // rewind the cell walk
    logic probe;        // read one neighbour or the cell itself
    logic store;        // write count and new state of the current cell
    logic copy;         // move one new state into the grid
    logic flush;        // last pending copy write
    logic out_load;     // fill the output register
    logic out_from_mem; // output from the read data, else zero
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic probe_last;
    logic cell_last;
    logic grid_empty;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lge_ctrl.sv =====
// controller state machine of the life generation engine
`timescale 1ns / 1ps
`default_nettype none

module lge_ctrl
  import lge_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire act_t     in_action,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_action)
            ACT_READ: begin
              state_nxt = S_EMIT;
            end
            ACT_STEP: begin
              if (stat.grid_empty) begin
                state_nxt = S_EMIT;
              end else begin
                cmd.cell_start = 1'b1;
                state_nxt      = S_PROBE;
              end
            end
            default: begin
              // write or unused code: zero result, straight out when room
              if (slot_free) begin
                cmd.out_load = 1'b1;
              end else begin
                state_nxt = S_EMIT;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.probe_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (stat.cell_last) begin
          cmd.cell_start = 1'b1;
          state_nxt      = S_COPY;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.cell_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lge_datapath.sv =====
// grid stores, configuration, cell walk and neighbour counting
`timescale 1ns / 1ps
`default_nettype none

module lge_datapath
  import lge_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire cfg_idx_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire act_t             in_action,
  input  wire logic [5:0]       in_col,
  input  wire logic [5:0]       in_row,
  input  wire logic             in_alive_in,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output logic                  out_alive_out,
  output logic [CNT_W-1:0]      out_neighbour_count
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int XW0   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int XW    = (RW + 1 > XW0) ? RW + 1 : XW0;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_WIDTH)) + AW'(c);
  endfunction

  // configuration
  logic [CFG_W-1:0] grid_width_r, grid_height_r;
  logic [XW-1:0]    eff_w, eff_h;

  // stores
  logic             alive_mem [DEPTH];
  logic [CNT_W-1:0] nbr_mem   [DEPTH];
  logic             next_mem  [DEPTH];
  logic             alive_rdata_r, next_rdata_r;
  logic [CNT_W-1:0] nbr_rdata_r;

  // walk state
  logic [AW-1:0]    clr_r;
  logic [RW-1:0]    r_r;
  logic [CW-1:0]    c_r;
  probe_t           p_r;
  cnt_t             cnt_r;
  logic             use_r;
  logic             pend_r;
  logic [AW-1:0]    pend_addr_r;
  logic             res_read_r;

  logic             out_alive_r;
  cnt_t             out_cnt_r;

  logic [XW-1:0]    r_inc, c_inc;
  logic             row_end;
  logic [RW-1:0]    nb_row;
  logic [CW-1:0]    nb_col;
  logic             row_ok, col_ok;
  logic [AW-1:0]    cur_addr, in_addr, nb_addr;
  logic             in_grid, do_write, do_read, next_alive;

  logic             alive_we, alive_re;
  logic [AW-1:0]    alive_waddr, alive_raddr;
  logic             alive_wdata;
  logic             nbr_we;
  logic [AW-1:0]    nbr_waddr;
  cnt_t             nbr_wdata;

  assign eff_w = (XW'(grid_width_r) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(grid_width_r);
  assign eff_h = (XW'(grid_height_r) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT)
                                                          : XW'(grid_height_r);

  assign in_grid  = (XW'(in_col) < eff_w) && (XW'(in_row) < eff_h);
  assign in_addr  = cell_addr(RW'(in_row), CW'(in_col));
  assign cur_addr = cell_addr(r_r, c_r);
  assign do_write = cmd.accept && (in_action == ACT_WRITE) && in_grid;
  assign do_read  = cmd.accept && (in_action == ACT_READ) && in_grid;

  assign r_inc   = XW'(r_r) + XW'(1);
  assign c_inc   = XW'(c_r) + XW'(1);
  assign row_end = (c_inc == eff_w);

  assign stat.clr_last   = (clr_r == AW'(DEPTH - 1));
  assign stat.probe_last = (p_r == PROBE_CENTER);
  assign stat.cell_last  = row_end && (r_inc == eff_h);
  assign stat.grid_empty = (eff_w == '0) || (eff_h == '0);

  // neighbour coordinates; cells off the grid count as dead
  always_comb begin
    unique case (probe_row_ofs(p_r))
      OFS_DEC: begin
        row_ok = (r_r != '0);
        nb_row = r_r - RW'(1);
      end
      OFS_INC: begin
        row_ok = (r_inc < eff_h);
        nb_row = RW'(r_inc);
      end
      default: begin
        row_ok = 1'b1;
        nb_row = r_r;
      end
    endcase
    unique case (probe_col_ofs(p_r))
      OFS_DEC: begin
        col_ok = (c_r != '0);
        nb_col = c_r - CW'(1);
      end
      OFS_INC: begin
        col_ok = (c_inc < eff_w);
        nb_col = CW'(c_inc);
      end
      default: begin
        col_ok = 1'b1;
        nb_col = c_r;
      end
    endcase
  end

  assign nb_addr = cell_addr(nb_row, nb_col);

  assign next_alive = alive_rdata_r ? ((cnt_r == SURVIVE_LOW) || (cnt_r == BIRTH_COUNT))
                                    : (cnt_r == BIRTH_COUNT);

  // store port selection
  always_comb begin
    alive_we    = 1'b0;
    alive_waddr = cur_addr;
    alive_wdata = 1'b0;
    if (cmd.clear) begin
      alive_we    = 1'b1;
      alive_waddr = clr_r;
    end else if (do_write) begin
      alive_we    = 1'b1;
      alive_waddr = in_addr;
      alive_wdata = in_alive_in;
    end else if ((cmd.copy || cmd.flush) && pend_r) begin
      alive_we    = 1'b1;
      alive_waddr = pend_addr_r;
      alive_wdata = next_rdata_r;
    end

    alive_re    = do_read || cmd.probe;
    alive_raddr = cmd.probe ? nb_addr : in_addr;

    nbr_we    = cmd.clear || cmd.store;
    nbr_waddr = cmd.clear ? clr_r : cur_addr;
    nbr_wdata = cmd.clear ? '0 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (alive_we) begin
      alive_mem[alive_waddr] <= alive_wdata;
    end
    if (alive_re) begin
      alive_rdata_r <= alive_mem[alive_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_waddr] <= nbr_wdata;
    end
    if (do_read) begin
      nbr_rdata_r <= nbr_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      next_mem[cur_addr] <= next_alive;
    end
    if (cmd.copy) begin
      next_rdata_r <= next_mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy) begin
      pend_addr_r <= cur_addr;
    end
    if (cmd.out_load) begin
      out_alive_r <= cmd.out_from_mem && res_read_r && alive_rdata_r;
      out_cnt_r   <= (cmd.out_from_mem && res_read_r) ? nbr_rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
      clr_r         <= '0;
      r_r           <= '0;
      c_r           <= '0;
      p_r           <= '0;
      cnt_r         <= '0;
      use_r         <= 1'b0;
      pend_r        <= 1'b0;
      res_read_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.accept) begin
        res_read_r <= (in_action == ACT_READ) && in_grid;
      end
      if (cmd.cell_start) begin
        r_r    <= '0;
        c_r    <= '0;
        p_r    <= '0;
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end else begin
        if (cmd.probe) begin
          p_r   <= p_r + PROBE_W'(1);
          use_r <= row_ok && col_ok;
          // data of the previous probe arrives now
          if ((p_r != '0) && use_r) begin
            cnt_r <= cnt_r + CNT_W'(alive_rdata_r);
          end
        end
        if (cmd.store) begin
          p_r   <= '0;
          cnt_r <= '0;
        end
        if (cmd.store || cmd.copy) begin
          if (row_end) begin
            c_r <= '0;
            r_r <= RW'(r_inc);
          end else begin
            c_r <= CW'(c_inc);
          end
        end
        if (cmd.copy) begin
          pend_r <= 1'b1;
        end
        if (cmd.flush) begin
          pend_r <= 1'b0;
        end
      end
    end
  end

  assign out_alive_out       = out_alive_r;
  assign out_neighbour_count = out_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/life_generation_engine.sv =====
// life generation engine top level: B3/S23 on a bounded grid
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_action, in_col, in_row, in_alive_in
//   out_     output     out_valid / out_ready  out_alive_out, out_neighbour_count
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// after reset both stores are cleared one entry a cycle, with in_ready low
// until the last entry is done (configuration writes are taken throughout)
// write and unused codes load a zero result at once when the output has room; a read
// goes through the emit state (registered store read); a step walks the grid in use:
// nine reads per cell on the single cell read port plus the store, then a copy back
// of each cell; one item is worked at a time; a result waiting in the output register
// does not block the next item from being accepted and executed
`timescale 1ns / 1ps
`default_nettype none

module life_generation_engine
  import lge_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_action,
  input  wire logic [5:0]       in_col,
  input  wire logic [5:0]       in_row,
  input  wire logic             in_alive_in,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_alive_out,
  output logic [3:0]            out_neighbour_count,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire cfg_idx_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lge_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_action           (in_action),
    .in_col              (in_col),
    .in_row              (in_row),
    .in_alive_in         (in_alive_in),
    .cmd                 (cmd),
    .stat                (stat),
    .out_alive_out       (out_alive_out),
    .out_neighbour_count (out_neighbour_count)
  );

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.probe, cmd.store, cmd.copy, cmd.flush, cmd.accept}))
    else $error("more than one datapath phase active");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register loaded over an unread result");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_action == ACT_STEP && !stat.grid_empty) |=> !in_ready)
    else $error("input taken during a generation step");

  a_probe_store: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.probe && stat.probe_last) |=> cmd.store)
    else $error("last probe not followed by the cell store");

endmodule

`default_nettype wire

// ===== verif/tb_life_generation_engine.sv =====
// self-checking testbench for the life generation engine: directed and random cell operations
`timescale 1ns / 1ps

module tb_life_generation_engine;
  import lge_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int MAX_CELLS = MAX_COLS * MAX_ROWS;
  localparam act_t ACT_SPARE = 2'd3;
  localparam int LONG_HOLD = 250;
  localparam int STEP_AREA_LIMIT = 160;
  localparam int RANDOM_OPS = 1700;

  typedef struct {
    act_t       action;
    logic [5:0] col;
    logic [5:0] row;
    logic       alive;
  } cell_op_t;

  typedef struct {
    logic       alive;
    logic [3:0] count;
  } cell_report_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_action = ACT_WRITE;
  logic [5:0]       in_col = '0;
  logic [5:0]       in_row = '0;
  logic             in_alive_in = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_alive_out;
  logic [3:0]       out_neighbour_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = CFG_GRID_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow of the grid and its settings
  bit         alive_map [MAX_CELLS];
  bit [3:0]   count_map [MAX_CELLS];
  bit         next_map  [MAX_CELLS];
  int         grid_cols = GRID_RESET;
  int         grid_rows = GRID_RESET;

  cell_op_t     op_queue[$];
  cell_report_t cell_reports_due[$];

  int items_queued = 0;
  int items_taken = 0;
  int errors = 0;
  int n_writes = 0, n_reads = 0, n_steps = 0, n_spare = 0, n_cfg = 0;
  int hold_requests = 0, holds_granted = 0;
  bit in_taken = 1'b0;

  life_generation_engine #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_alive_in        (in_alive_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_alive_out      (out_alive_out),
    .out_neighbour_count(out_neighbour_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", cell_reports_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int clamp_dim(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int draw_pause();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  // coordinate mostly inside the grid in use, sometimes anywhere
  function automatic logic [5:0] pick_coord(input int lim);
    if (lim > 0 && $urandom_range(99) < 85) return 6'($urandom_range(lim - 1, 0));
    return 6'($urandom_range(63, 0));
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // applies one accepted item to the shadow grid and queues the result it owes
  task automatic predict_cell_op(input act_t a, input logic [5:0] c, input logic [5:0] r,
                                 input logic v);
    cell_report_t rep;
    int w, h, idx, n, yy, xx;
    bit inside_grid;
    w = clamp_dim(grid_cols, MAX_COLS);
    h = clamp_dim(grid_rows, MAX_ROWS);
    inside_grid = (int'(c) < w) && (int'(r) < h);
    idx = int'(r) * MAX_COLS + int'(c);
    rep = '{1'b0, 4'd0};
    case (a)
      ACT_WRITE: begin
        if (inside_grid) alive_map[idx] = v;
      end
      ACT_STEP: begin
        for (int y = 0; y < h; y++) begin
          for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                yy = y + dy;
                xx = x + dx;
                if ((dy != 0 || dx != 0) && yy >= 0 && xx >= 0 && yy < h && xx < w)
                  n += alive_map[yy * MAX_COLS + xx];
              end
            end
            next_map[y * MAX_COLS + x] = alive_map[y * MAX_COLS + x] ?
                (n == SURVIVE_LOW || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
            count_map[y * MAX_COLS + x] = 4'(n);
          end
        end
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            alive_map[y * MAX_COLS + x] = next_map[y * MAX_COLS + x];
      end
      ACT_READ: begin
        if (inside_grid) rep = '{alive_map[idx], count_map[idx]};
      end
      default: ;
    endcase
    cell_reports_due.push_back(rep);
  endtask

  // result checking, item and register tracking
  always @(posedge clk) begin
    cell_report_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (cell_reports_due.size() == 0) begin
          flag_mismatch("result with no item waiting for it");
        end else begin
          want = cell_reports_due.pop_front();
          if (out_alive_out !== want.alive)
            flag_mismatch($sformatf("alive_out got %b want %b", out_alive_out, want.alive));
          if (out_neighbour_count !== want.count)
            flag_mismatch($sformatf("neighbour_count got %0d want %0d",
                                    out_neighbour_count, want.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GRID_WIDTH) grid_cols = cfg_data;
        else grid_rows = cfg_data;
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        items_taken++;
        case (act_t'(in_action))
          ACT_WRITE: n_writes++;
          ACT_STEP:  n_steps++;
          ACT_READ:  n_reads++;
          default:   n_spare++;
        endcase
        predict_cell_op(in_action, in_col, in_row, in_alive_in);
      end
    end
  end

  // sender: feeds items from op_queue with random gaps
  int gap_left = 0;
  int send_calm = 0;
  always @(negedge clk) begin
    cell_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // item still on offer
    end else begin
      if (in_taken) begin
        if (send_calm > 0) begin
          send_calm--;
          gap_left = 0;
        end else begin
          gap_left = draw_pause();
          if ($urandom_range(39) == 0) send_calm = $urandom_range(60, 20);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        op = op_queue.pop_front();
        in_action <= op.action;
        in_col <= op.col;
        in_row <= op.row;
        in_alive_in <= op.alive;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus long holds on request
  int stall_left = 0;
  int recv_calm = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (holds_granted != hold_requests) begin
        holds_granted++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(39) == 0) recv_calm = $urandom_range(60, 20);
        else if ($urandom_range(9) < 3) stall_left = draw_pause();
      end
    end
  end

  task automatic queue_op(input act_t a, input logic [5:0] c, input logic [5:0] r,
                          input logic v);
    op_queue.push_back('{a, c, r, v});
    items_queued++;
  endtask

  task automatic await_quiet();
    while (items_taken != items_queued || cell_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic set_grid(input int w, input int h);
    await_quiet();
    repeat (8) @(posedge clk);
    cfg_write(CFG_GRID_WIDTH, w);
    cfg_write(CFG_GRID_HEIGHT, h);
  endtask

  initial begin : stimulus
    int w, h, cw, ch, m, p, n, seeds, area, rand_ops, phase;
    bit steps_ok;
    act_t a;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners of the full grid, one full generation
    set_grid(64, 64);
    queue_op(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    queue_op(ACT_WRITE, 6'd63, 6'd63, 1'b1);
    queue_op(ACT_WRITE, 6'd62, 6'd63, 1'b1);
    queue_op(ACT_WRITE, 6'd63, 6'd62, 1'b1);
    queue_op(ACT_READ, 6'd63, 6'd63, 1'b0);
    queue_op(ACT_READ, 6'd0, 6'd0, 1'b1);
    queue_op(ACT_SPARE, 6'd63, 6'd63, 1'b1);
    queue_op(ACT_STEP, 6'd63, 6'd0, 1'b1);
    queue_op(ACT_READ, 6'd63, 6'd63, 1'b0);
    queue_op(ACT_READ, 6'd62, 6'd62, 1'b0);
    queue_op(ACT_WRITE, 6'd0, 6'd0, 1'b0);
    queue_op(ACT_READ, 6'd0, 6'd0, 1'b0);

    // blinker on a 3x3 grid, out-of-range write and read
    set_grid(3, 3);
    queue_op(ACT_WRITE, 6'd1, 6'd0, 1'b1);
    queue_op(ACT_WRITE, 6'd1, 6'd1, 1'b1);
    queue_op(ACT_WRITE, 6'd1, 6'd2, 1'b1);
    queue_op(ACT_WRITE, 6'd5, 6'd1, 1'b1);
    queue_op(ACT_STEP, 6'd0, 6'd0, 1'b0);
    queue_op(ACT_READ, 6'd0, 6'd1, 1'b0);
    queue_op(ACT_READ, 6'd1, 6'd1, 1'b0);
    queue_op(ACT_READ, 6'd5, 6'd1, 1'b0);

    // zero width: nothing in use
    set_grid(0, 3);
    queue_op(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    queue_op(ACT_READ, 6'd0, 6'd0, 1'b0);
    queue_op(ACT_STEP, 6'd0, 6'd0, 1'b0);

    // oversized values clamp, hidden cells come back
    set_grid(100, 127);
    queue_op(ACT_READ, 6'd63, 6'd63, 1'b0);
    queue_op(ACT_READ, 6'd1, 6'd1, 1'b0);

    set_grid(1, 1);
    queue_op(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    queue_op(ACT_STEP, 6'd0, 6'd0, 1'b0);
    queue_op(ACT_READ, 6'd0, 6'd0, 1'b0);

    rand_ops = 0;
    phase = 0;
    while (rand_ops < RANDOM_OPS) begin
      m = $urandom_range(99);
      if (m < 55) begin
        w = $urandom_range(10, 1);
        h = $urandom_range(10, 1);
      end else if (m < 67) begin
        w = $urandom_range(64, 24);
        h = $urandom_range(2, 1);
      end else if (m < 77) begin
        w = $urandom_range(2, 1);
        h = $urandom_range(64, 24);
      end else if (m < 90) begin
        w = $urandom_range(127, 40);
        h = $urandom_range(127, 40);
      end else begin
        w = ($urandom_range(1) != 0) ? 0 : $urandom_range(127, 0);
        h = (w != 0) ? 0 : $urandom_range(127, 0);
      end
      set_grid(w, h);
      if (phase == 1 || phase == 6) hold_requests++;
      cw = clamp_dim(w, MAX_COLS);
      ch = clamp_dim(h, MAX_ROWS);
      area = cw * ch;
      steps_ok = area <= STEP_AREA_LIMIT;

      // seed a pattern before stepping it
      seeds = (steps_ok && area > 0) ? ((area < 40) ? area : 40) : 0;
      for (int i = 0; i < seeds; i++)
        queue_op(ACT_WRITE, pick_coord(cw), pick_coord(ch), 1'($urandom_range(1)));

      n = $urandom_range(70, 30);
      for (int i = 0; i < n; i++) begin
        p = $urandom_range(99);
        if (p < 3) a = ACT_SPARE;
        else if (p < 13 && steps_ok) a = ACT_STEP;
        else if (p < 55) a = ACT_WRITE;
        else a = ACT_READ;
        queue_op(a, pick_coord(cw), pick_coord(ch), 1'($urandom_range(1)));
      end
      rand_ops += seeds + n;
      phase++;
    end

    await_quiet();
    repeat (20) @(posedge clk);
    $display("ran %0d items: %0d writes, %0d reads, %0d generations, %0d unused codes",
             items_taken, n_writes, n_reads, n_steps, n_spare);
    $display("%0d register writes over %0d random grid sizes, %0d long output holds",
             n_cfg, phase, holds_granted);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
